/* sv/alcp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alcp_pkg
// Types, character constants and decode helpers shared by the LED command
// parser and its response emitter.
// ----------------------------------------------------------------------------
package alcp_pkg;

   localparam int POS_W = 6;

   localparam logic [7:0] CHAR_NUL  = 8'h00;
   localparam logic [7:0] CHAR_NL   = 8'h0A;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_ONE  = 8'h31;

   localparam logic [2:0] COLOR_NONE   = 3'd0;
   localparam logic [2:0] COLOR_GREEN  = 3'd1;
   localparam logic [2:0] COLOR_ORANGE = 3'd2;
   localparam logic [2:0] COLOR_RED    = 3'd3;
   localparam logic [2:0] COLOR_BLUE   = 3'd4;
   localparam logic [2:0] COLOR_ALL    = 3'd5;

   localparam logic [1:0] LEVEL_BAD = 2'd0;
   localparam logic [1:0] LEVEL_OFF = 2'd1;
   localparam logic [1:0] LEVEL_ON  = 2'd2;

   typedef enum logic [1:0] {
      RESP_OK,
      RESP_ERR,
      RESP_STA
   } resp_kind_type;

   typedef struct packed {
      resp_kind_type kind;
      logic [3:0]    leds;
   } resp_desc_type;

   // "LED:"
   function automatic logic [7:0] led_word_char(input logic [1:0] idx);
      logic [7:0] c;
      unique case (idx)
         2'd0:    c = 8'h4C;
         2'd1:    c = 8'h45;
         2'd2:    c = 8'h44;
         default: c = 8'h3A;
      endcase
      return c;
   endfunction

   // "GET:LED"
   function automatic logic [7:0] get_word_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h47;
         3'd1:    c = 8'h45;
         3'd2:    c = 8'h54;
         3'd3:    c = 8'h3A;
         3'd4:    c = 8'h4C;
         3'd5:    c = 8'h45;
         3'd6:    c = 8'h44;
         default: c = CHAR_NUL;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] decode_color(input logic [7:0] c);
      logic [2:0] code;
      unique case (c)
         8'h47:   code = COLOR_GREEN;
         8'h4F:   code = COLOR_ORANGE;
         8'h52:   code = COLOR_RED;
         8'h42:   code = COLOR_BLUE;
         8'h41:   code = COLOR_ALL;
         default: code = COLOR_NONE;
      endcase
      return code;
   endfunction

   function automatic logic [3:0] resp_last_idx(input resp_kind_type kind);
      logic [3:0] n;
      unique case (kind)
         RESP_OK:  n = 4'd2;
         RESP_STA: n = 4'd8;
         default:  n = 4'd3;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] resp_char(input resp_kind_type kind,
                                            input logic [3:0]    idx,
                                            input logic [3:0]    leds);
      logic [7:0] c;
      c = CHAR_NL;
      unique case (kind)
         RESP_OK: begin
            unique case (idx)
               4'd0:    c = 8'h4F;
               4'd1:    c = 8'h4B;
               default: c = CHAR_NL;
            endcase
         end
         RESP_STA: begin
            unique case (idx)
               4'd0:    c = 8'h53;
               4'd1:    c = 8'h54;
               4'd2:    c = 8'h41;
               4'd3:    c = 8'h3A;
               4'd4:    c = CHAR_ZERO | {7'd0, leds[0]};
               4'd5:    c = CHAR_ZERO | {7'd0, leds[1]};
               4'd6:    c = CHAR_ZERO | {7'd0, leds[2]};
               4'd7:    c = CHAR_ZERO | {7'd0, leds[3]};
               default: c = CHAR_NL;
            endcase
         end
         default: begin
            unique case (idx)
               4'd0:    c = 8'h45;
               4'd1:    c = 8'h52;
               4'd2:    c = 8'h52;
               default: c = CHAR_NL;
            endcase
         end
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

/* sv/alcp_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alcp_parser
// Tracks the command text of a frame byte by byte, holds the LED flags and
// raises one response descriptor when a frame ends or a link error arrives.
// ----------------------------------------------------------------------------
module alcp_parser #(
   parameter int FRAME_BYTES = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic [7:0]             rx_byte,
   input  wire logic                   frame_end,
   input  wire logic                   transfer_error,
   output logic                        desc_valid,
   output alcp_pkg::resp_desc_type     desc
);

   localparam logic [alcp_pkg::POS_W-1:0] LAST_POS = alcp_pkg::POS_W'(FRAME_BYTES - 1);

   logic [alcp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       term_ff, term_in;
   logic                       led_ok_ff, led_ok_in;
   logic                       get_ok_ff, get_ok_in;
   logic [2:0]                 color_ff, color_in;
   logic [1:0]                 level_ff, level_in;
   logic [3:0]                 leds_ff, leds_in;
   logic                       in_cmd;
   logic                       more;
   logic [3:0]                 mask;
   logic                       resp;

   assign in_cmd = !term_ff && (pos_ff < LAST_POS);
   assign more   = !frame_end && (pos_ff < LAST_POS);

   always_comb begin
      pos_in    = pos_ff;
      term_in   = term_ff;
      led_ok_in = led_ok_ff;
      get_ok_in = get_ok_ff;
      color_in  = color_ff;
      level_in  = level_ff;
      leds_in   = leds_ff;
      resp      = 1'b0;
      desc.kind = alcp_pkg::RESP_ERR;
      desc.leds = leds_ff;
      mask      = (color_ff == alcp_pkg::COLOR_ALL) ? 4'hF : 4'h0;

      if (in_cmd) begin
         if (rx_byte == alcp_pkg::CHAR_NUL || rx_byte == alcp_pkg::CHAR_NL) begin
            term_in = 1'b1;
         end
         if (pos_ff < alcp_pkg::POS_W'(4)
             && rx_byte != alcp_pkg::led_word_char(pos_ff[1:0])) begin
            led_ok_in = 1'b0;
         end
         if (pos_ff < alcp_pkg::POS_W'(7)
             && rx_byte != alcp_pkg::get_word_char(pos_ff[2:0])) begin
            get_ok_in = 1'b0;
         end
         if (!term_in) begin
            if (pos_ff == alcp_pkg::POS_W'(4)) begin
               color_in = alcp_pkg::decode_color(rx_byte);
            end else if (pos_ff == alcp_pkg::POS_W'(5)) begin
               level_in = (rx_byte == alcp_pkg::CHAR_ZERO) ? alcp_pkg::LEVEL_OFF :
                          (rx_byte == alcp_pkg::CHAR_ONE)  ? alcp_pkg::LEVEL_ON  :
                                                             alcp_pkg::LEVEL_BAD;
            end
         end
      end

      if (color_in == alcp_pkg::COLOR_ALL) begin
         mask = 4'hF;
      end else begin
         mask = 4'b0001 << (color_in - 3'd1);
      end

      if (!transfer_error && more) begin
         pos_in = pos_ff + alcp_pkg::POS_W'(1);
      end else begin
         resp = 1'b1;
         if (transfer_error) begin
            // link error: drop the frame, keep the flags
            desc.kind = alcp_pkg::RESP_ERR;
         end else if (led_ok_in && pos_ff >= alcp_pkg::POS_W'(5)
                      && color_in != alcp_pkg::COLOR_NONE
                      && level_in != alcp_pkg::LEVEL_BAD) begin
            leds_in   = (level_in == alcp_pkg::LEVEL_ON) ? (leds_ff | mask)
                                                         : (leds_ff & ~mask);
            desc.kind = alcp_pkg::RESP_OK;
         end else if (get_ok_in && pos_ff >= alcp_pkg::POS_W'(6)) begin
            desc.kind = alcp_pkg::RESP_STA;
         end else begin
            desc.kind = alcp_pkg::RESP_ERR;
         end
         desc.leds = leds_in;
         pos_in    = '0;
         term_in   = 1'b0;
         led_ok_in = 1'b1;
         get_ok_in = 1'b1;
         color_in  = alcp_pkg::COLOR_NONE;
         level_in  = alcp_pkg::LEVEL_BAD;
      end
   end

   assign desc_valid = accept && resp;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         term_ff   <= 1'b0;
         led_ok_ff <= 1'b1;
         get_ok_ff <= 1'b1;
         color_ff  <= alcp_pkg::COLOR_NONE;
         level_ff  <= alcp_pkg::LEVEL_BAD;
         leds_ff   <= 4'h0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         term_ff   <= term_in;
         led_ok_ff <= led_ok_in;
         get_ok_ff <= get_ok_in;
         color_ff  <= color_in;
         level_ff  <= level_in;
         leds_ff   <= leds_in;
      end
   end

endmodule
`default_nettype wire

/* sv/alcp_emitter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alcp_emitter
// Holds one waiting response descriptor and plays the active one out as a
// string of character beats, marking the newline as the last beat.
// ----------------------------------------------------------------------------
module alcp_emitter (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    desc_valid,
   input  wire alcp_pkg::resp_desc_type desc,
   output logic                         desc_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [7:0]                   rsp_resp_char,
   output logic                         rsp_resp_last,
   output logic [3:0]                   rsp_led_flags
);

   logic                    pend_valid_ff;
   alcp_pkg::resp_desc_type pend_ff;
   logic                    act_valid_ff;
   alcp_pkg::resp_desc_type act_ff;
   logic [3:0]              idx_ff;
   logic                    beat;
   logic                    done;
   logic                    load_pend;
   logic                    load_new;
   logic                    load;

   assign desc_ready    = !pend_valid_ff;
   assign rsp_valid     = act_valid_ff;
   assign rsp_resp_char = alcp_pkg::resp_char(act_ff.kind, idx_ff, act_ff.leds);
   assign rsp_resp_last = (idx_ff == alcp_pkg::resp_last_idx(act_ff.kind));
   assign rsp_led_flags = act_ff.leds;

   assign beat      = act_valid_ff && rsp_ready;
   assign done      = beat && rsp_resp_last;
   assign load_pend = pend_valid_ff && (!act_valid_ff || done);
   // take a new descriptor straight into the active slot when that slot frees
   assign load_new  = desc_valid && !pend_valid_ff && (!act_valid_ff || done);
   assign load      = load_pend || load_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         act_valid_ff  <= 1'b0;
         idx_ff        <= 4'd0;
      end else begin
         if (desc_valid && !load_new) begin
            pend_valid_ff <= 1'b1;
         end else if (load_pend) begin
            pend_valid_ff <= 1'b0;
         end
         if (load) begin
            act_valid_ff <= 1'b1;
            idx_ff       <= 4'd0;
         end else if (done) begin
            act_valid_ff <= 1'b0;
            idx_ff       <= 4'd0;
         end else if (beat) begin
            // advance to the next character
            idx_ff <= idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (desc_valid) begin
         pend_ff <= desc;
      end
      if (load_pend) begin
         act_ff <= pend_ff;
      end else if (load_new) begin
         act_ff <= desc;
      end
   end

endmodule
`default_nettype wire

/* sv/ascii_led_command_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_led_command_parser
// Parses "LED:<colour><level>" and "GET:LED" commands from a byte frame of
// up to FRAME_BYTES bytes and answers with "OK\n", "STA:dddd\n" or "ERR\n".
//
//   channel | direction | beat carries
//   --------+-----------+------------------------------------------------
//   req_    | in        | rx_byte, frame_end, transfer_error (one byte)
//   rsp_    | out       | resp_char, resp_last, led_flags (one character)
//
// Each request byte is parsed in the cycle it is accepted; a byte that ends
// the frame or reports a link error also loads a response descriptor, straight
// into the active slot when that slot is free. The emitter then sends one
// character per cycle while rsp_ready is high (3, 4 or 9 beats), starting
// the cycle after the descriptor moves up, and request bytes keep flowing
// during the drain of an answer. req_ready falls only while one response is
// already waiting behind the one being sent. Synchronous reset clears the
// parse state, the LED flags and both response slots.
// ----------------------------------------------------------------------------
module ascii_led_command_parser #(
   parameter int FRAME_BYTES = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_frame_end,
   input  wire logic       req_transfer_error,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_resp_char,
   output logic            rsp_resp_last,
   output logic [3:0]      rsp_led_flags
);

   logic                    accept;
   logic                    desc_valid;
   alcp_pkg::resp_desc_type desc;

   assign accept = req_valid && req_ready;

   alcp_parser #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .rx_byte        (req_rx_byte),
      .frame_end      (req_frame_end),
      .transfer_error (req_transfer_error),
      .desc_valid     (desc_valid),
      .desc           (desc)
   );

   alcp_emitter u_emitter (
      .clock         (clock),
      .reset         (reset),
      .desc_valid    (desc_valid),
      .desc          (desc),
      .desc_ready    (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_resp_char (rsp_resp_char),
      .rsp_resp_last (rsp_resp_last),
      .rsp_led_flags (rsp_led_flags)
   );

endmodule
`default_nettype wire
